// ===== design/tvbm_pkg.sv =====
package tvbm_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
    localparam int CNT_BITS  = $clog2(NUM_BITS);
    localparam int PC_BITS   = 6;

    localparam int SCALE_BITS     = 19;
    localparam int THR_BITS       = 31;
    localparam int CW_BITS        = 17;
    localparam int INV_BITS       = 31;
    localparam int CFG_DATA_BITS  = 31;
    localparam int CFG_INDEX_BITS = 3;

    // Register indexes on the configuration channel.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SLOPE_SCALE,
        REG_TVB_THRESHOLD,
        REG_CELL_WIDTH,
        REG_INV_CELL_WIDTH,
        REG_LIMIT_MODE
    } t_reg;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic [WORD_BITS-1:0]        t_mag;
    typedef logic [2*WORD_BITS-1:0]      t_wide;

    localparam t_mag  WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_HI  = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_LO  = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MULQ,
        OP_HALF,
        OP_MINMOD,
        OP_DIV,
        OP_BRM,
        OP_JOUT
    } t_op;

    typedef enum logic [4:0] {
        S_XS, S_XSS, S_XP, S_XPS,
        S_HSM, S_HSS, S_HPM, S_HPS,
        S_OSM, S_OPM,
        S_CW, S_INV, S_SCALE,
        S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7, S_T8, S_T9,
        S_NONE
    } t_src;

    typedef enum logic [3:0] {
        D_T0, D_T1, D_T2, D_T3, D_T4, D_T5, D_T6, D_T7, D_T8, D_T9,
        D_NONE
    } t_dst;

    typedef struct packed {
        t_op  op;
        t_dst dst;
        t_src a;
        t_src b;
        t_src c;
        logic last;
    } t_uop;

    typedef struct packed {
        logic  start;
        t_word num;
        t_word den;
    } t_div_req;

    typedef struct packed {
        logic  done;
        logic  fault;
        t_word quot;
    } t_div_rsp;

    localparam logic [PC_BITS-1:0] PC_LIMIT     = PC_BITS'(0);
    localparam logic [PC_BITS-1:0] PC_MODE1     = PC_BITS'(16);
    localparam logic [PC_BITS-1:0] PC_OUT       = PC_BITS'(39);
    localparam logic [PC_BITS-1:0] PC_PASS_HELD = PC_BITS'(45);
    localparam logic [PC_BITS-1:0] PC_PASS_IN   = PC_BITS'(51);

    function automatic t_mag mag_of(input t_word v);
        t_mag u;
        u = v;
        return v[WORD_BITS-1] ? (~u + 1'b1) : u;
    endfunction

    // Saturates a magnitude into the signed word range with the given sign.
    function automatic t_word from_mag(input logic neg, input t_wide mag);
        t_wide lim;
        t_wide m;
        t_mag  r;
        lim = {{WORD_BITS{1'b0}}, WORD_MAX} + {{(2*WORD_BITS-1){1'b0}}, neg};
        m   = (mag > lim) ? lim : mag;
        r   = m[WORD_BITS-1:0];
        return neg ? t_word'(~r + 1'b1) : t_word'(r);
    endfunction

    function automatic t_word sat_add(input t_word a, input t_word b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            return s[WORD_BITS] ? WORD_LO : WORD_HI;
        end
        return s[WORD_BITS-1:0];
    endfunction

    function automatic t_word sat_sub(input t_word a, input t_word b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            return s[WORD_BITS] ? WORD_LO : WORD_HI;
        end
        return s[WORD_BITS-1:0];
    endfunction

    // Product of magnitudes shifted right, truncated toward zero, saturated.
    function automatic t_word mul_shift(input t_word a, input t_word b, input logic half);
        t_wide p;
        t_wide q;
        p = {{WORD_BITS{1'b0}}, mag_of(a)} * {{WORD_BITS{1'b0}}, mag_of(b)};
        q = half ? (p >> (FRAC_BITS + 1)) : (p >> FRAC_BITS);
        return from_mag(a[WORD_BITS-1] ^ b[WORD_BITS-1], q);
    endfunction

    function automatic t_uop mk(input t_op op, input t_dst d, input t_src a, input t_src b,
                                input t_src c, input logic last);
        t_uop u;
        u.op   = op;
        u.dst  = d;
        u.a    = a;
        u.b    = b;
        u.c    = c;
        u.last = last;
        return u;
    endfunction

    // Microprogram: limiting of a held cell, the node outputs, and pass-through.
    function automatic t_uop uop_at(input logic [PC_BITS-1:0] pc);
        t_uop u;
        case (pc)
            6'd0:  u = mk(OP_SUB,    D_T0, S_HSM,   S_OSM,   S_NONE, 1'b0);
            6'd1:  u = mk(OP_MULQ,   D_T0, S_T0,    S_INV,   S_NONE, 1'b0);
            6'd2:  u = mk(OP_MULQ,   D_T0, S_SCALE, S_T0,    S_NONE, 1'b0);
            6'd3:  u = mk(OP_SUB,    D_T1, S_XS,    S_HSM,   S_NONE, 1'b0);
            6'd4:  u = mk(OP_MULQ,   D_T1, S_T1,    S_INV,   S_NONE, 1'b0);
            6'd5:  u = mk(OP_MULQ,   D_T1, S_T1,    S_SCALE, S_NONE, 1'b0);
            6'd6:  u = mk(OP_MINMOD, D_T2, S_HSS,   S_T0,    S_T1,   1'b0);
            6'd7:  u = mk(OP_BRM,    D_NONE, S_NONE, S_NONE, S_NONE, 1'b0);
            6'd8:  u = mk(OP_SUB,    D_T0, S_HPM,   S_OPM,   S_NONE, 1'b0);
            6'd9:  u = mk(OP_MULQ,   D_T0, S_T0,    S_INV,   S_NONE, 1'b0);
            6'd10: u = mk(OP_MULQ,   D_T0, S_SCALE, S_T0,    S_NONE, 1'b0);
            6'd11: u = mk(OP_SUB,    D_T1, S_XP,    S_HPM,   S_NONE, 1'b0);
            6'd12: u = mk(OP_MULQ,   D_T1, S_T1,    S_INV,   S_NONE, 1'b0);
            6'd13: u = mk(OP_MULQ,   D_T1, S_T1,    S_SCALE, S_NONE, 1'b0);
            6'd14: u = mk(OP_MINMOD, D_T3, S_HPS,   S_T0,    S_T1,   1'b0);
            6'd15: u = mk(OP_JOUT,   D_NONE, S_NONE, S_NONE, S_NONE, 1'b0);
            6'd16: u = mk(OP_HALF,   D_T0, S_CW,    S_HSS,   S_NONE, 1'b0);
            6'd17: u = mk(OP_HALF,   D_T1, S_CW,    S_HPS,   S_NONE, 1'b0);
            6'd18: u = mk(OP_SUB,    D_T4, S_HSM,   S_T0,    S_NONE, 1'b0);
            6'd19: u = mk(OP_ADD,    D_T5, S_HSM,   S_T0,    S_NONE, 1'b0);
            6'd20: u = mk(OP_SUB,    D_T6, S_HPM,   S_T1,    S_NONE, 1'b0);
            6'd21: u = mk(OP_ADD,    D_T7, S_HPM,   S_T1,    S_NONE, 1'b0);
            6'd22: u = mk(OP_DIV,    D_T8, S_HPM,   S_HSM,   S_NONE, 1'b0);
            6'd23: u = mk(OP_DIV,    D_T9, S_OPM,   S_OSM,   S_NONE, 1'b0);
            6'd24: u = mk(OP_DIV,    D_T0, S_XP,    S_XS,    S_NONE, 1'b0);
            6'd25: u = mk(OP_DIV,    D_T1, S_T7,    S_T5,    S_NONE, 1'b0);
            6'd26: u = mk(OP_DIV,    D_T3, S_T6,    S_T4,    S_NONE, 1'b0);
            6'd27: u = mk(OP_SUB,    D_T3, S_T1,    S_T3,    S_NONE, 1'b0);
            6'd28: u = mk(OP_MULQ,   D_T3, S_T3,    S_INV,   S_NONE, 1'b0);
            6'd29: u = mk(OP_SUB,    D_T4, S_T8,    S_T9,    S_NONE, 1'b0);
            6'd30: u = mk(OP_MULQ,   D_T4, S_T4,    S_INV,   S_NONE, 1'b0);
            6'd31: u = mk(OP_MULQ,   D_T4, S_SCALE, S_T4,    S_NONE, 1'b0);
            6'd32: u = mk(OP_SUB,    D_T5, S_T0,    S_T8,    S_NONE, 1'b0);
            6'd33: u = mk(OP_MULQ,   D_T5, S_T5,    S_INV,   S_NONE, 1'b0);
            6'd34: u = mk(OP_MULQ,   D_T5, S_SCALE, S_T5,    S_NONE, 1'b0);
            6'd35: u = mk(OP_MINMOD, D_T6, S_T3,    S_T4,    S_T5,   1'b0);
            6'd36: u = mk(OP_MULQ,   D_T7, S_T8,    S_T2,    S_NONE, 1'b0);
            6'd37: u = mk(OP_MULQ,   D_T6, S_HSM,   S_T6,    S_NONE, 1'b0);
            6'd38: u = mk(OP_ADD,    D_T3, S_T7,    S_T6,    S_NONE, 1'b0);
            6'd39: u = mk(OP_HALF,   D_T0, S_CW,    S_T2,    S_NONE, 1'b0);
            6'd40: u = mk(OP_HALF,   D_T1, S_CW,    S_T3,    S_NONE, 1'b0);
            6'd41: u = mk(OP_SUB,    D_T4, S_HSM,   S_T0,    S_NONE, 1'b0);
            6'd42: u = mk(OP_ADD,    D_T5, S_HSM,   S_T0,    S_NONE, 1'b0);
            6'd43: u = mk(OP_SUB,    D_T6, S_HPM,   S_T1,    S_NONE, 1'b0);
            6'd44: u = mk(OP_ADD,    D_T7, S_HPM,   S_T1,    S_NONE, 1'b1);
            6'd45: u = mk(OP_HALF,   D_T0, S_CW,    S_HSS,   S_NONE, 1'b0);
            6'd46: u = mk(OP_HALF,   D_T1, S_CW,    S_HPS,   S_NONE, 1'b0);
            6'd47: u = mk(OP_SUB,    D_T4, S_HSM,   S_T0,    S_NONE, 1'b0);
            6'd48: u = mk(OP_ADD,    D_T5, S_HSM,   S_T0,    S_NONE, 1'b0);
            6'd49: u = mk(OP_SUB,    D_T6, S_HPM,   S_T1,    S_NONE, 1'b0);
            6'd50: u = mk(OP_ADD,    D_T7, S_HPM,   S_T1,    S_NONE, 1'b1);
            6'd51: u = mk(OP_HALF,   D_T0, S_CW,    S_XSS,   S_NONE, 1'b0);
            6'd52: u = mk(OP_HALF,   D_T1, S_CW,    S_XPS,   S_NONE, 1'b0);
            6'd53: u = mk(OP_SUB,    D_T4, S_XS,    S_T0,    S_NONE, 1'b0);
            6'd54: u = mk(OP_ADD,    D_T5, S_XS,    S_T0,    S_NONE, 1'b0);
            6'd55: u = mk(OP_SUB,    D_T6, S_XP,    S_T1,    S_NONE, 1'b0);
            6'd56: u = mk(OP_ADD,    D_T7, S_XP,    S_T1,    S_NONE, 1'b1);
            default: u = mk(OP_ADD,  D_NONE, S_NONE, S_NONE, S_NONE, 1'b1);
        endcase
        return u;
    endfunction

endpackage

// ===== design/tvbm_alu.sv =====
module tvbm_alu (
    input  tvbm_pkg::t_op  i_op,
    input  tvbm_pkg::t_word i_a,
    input  tvbm_pkg::t_word i_b,
    input  tvbm_pkg::t_word i_c,
    input  tvbm_pkg::t_mag  i_thr,
    output tvbm_pkg::t_word o_y
);
    import tvbm_pkg::*;

    t_mag ma;
    t_mag mb;
    t_mag mc;
    t_mag mmin;
    logic same_sign;
    t_word minmod_y;

    // TVB minmod: small slopes pass, otherwise the smallest magnitude when all
    // three agree in sign, else zero.
    always_comb begin
        ma        = mag_of(i_a);
        mb        = mag_of(i_b);
        mc        = mag_of(i_c);
        mmin      = ma;
        if (mb < mmin) begin
            mmin = mb;
        end
        if (mc < mmin) begin
            mmin = mc;
        end
        same_sign = (i_a != '0 && i_b != '0 && i_c != '0) &&
                    (i_a[WORD_BITS-1] == i_b[WORD_BITS-1]) &&
                    (i_a[WORD_BITS-1] == i_c[WORD_BITS-1]);
        if (ma < i_thr) begin
            minmod_y = i_a;
        end else if (same_sign) begin
            minmod_y = from_mag(i_a[WORD_BITS-1], {{WORD_BITS{1'b0}}, mmin});
        end else begin
            minmod_y = '0;
        end
    end

    always_comb begin
        case (i_op)
            OP_ADD:    o_y = sat_add(i_a, i_b);
            OP_SUB:    o_y = sat_sub(i_a, i_b);
            OP_MULQ:   o_y = mul_shift(i_a, i_b, 1'b0);
            OP_HALF:   o_y = mul_shift(i_a, i_b, 1'b1);
            OP_MINMOD: o_y = minmod_y;
            default:   o_y = '0;
        endcase
    end

endmodule

// ===== design/tvbm_div.sv =====
module tvbm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tvbm_pkg::t_div_req i_req,
    output tvbm_pkg::t_div_rsp o_rsp
);
    import tvbm_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic                r_dz;
    logic                r_neg;
    logic [CNT_BITS-1:0] r_cnt;
    logic [NUM_BITS-1:0] r_num;
    t_mag                r_rem;
    t_mag                r_den;

    logic [WORD_BITS:0] shifted;
    logic [WORD_BITS:0] diff;
    logic               fits;

    // Restoring division, one quotient bit per cycle; quotient bits shift into
    // the numerator register from the bottom.
    always_comb begin
        shifted = {r_rem, r_num[NUM_BITS-1]};
        diff    = shifted - {1'b0, r_den};
        fits    = shifted >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_neg <= i_req.num[WORD_BITS-1] ^ i_req.den[WORD_BITS-1];
                r_rem <= '0;
                r_cnt <= '0;
                r_den <= mag_of(i_req.den);
                if (i_req.den == '0) begin
                    // Saturates to the largest value of the dividend's sign.
                    r_dz   <= 1'b1;
                    r_neg  <= i_req.num[WORD_BITS-1];
                    r_num  <= (i_req.num != '0) ? '1 : '0;
                    r_done <= 1'b1;
                end else begin
                    r_dz   <= 1'b0;
                    r_num  <= {mag_of(i_req.num), {FRAC_BITS{1'b0}}};
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= fits ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
                r_num <= {r_num[NUM_BITS-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(NUM_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.fault = r_dz;
    assign o_rsp.quot  = from_mag(r_neg, {{(2*WORD_BITS-NUM_BITS){1'b0}}, r_num});

endmodule

// ===== design/tvb_minmod_slope_limiter_unit.sv =====
// From the input transaction to the result in the output register, a pass-through cell and
// a limited cell in mode 0 take only ST_RUN steps; in mode 1 five divisions on the single
// radix-2 divider add ST_DIV waits; a zero divisor finishes without iterating. One cell at
// a time. A row end that also releases a held cell then yields the new cell's result too.
// Input is ready again once the last result is loaded and the window committed, so an
// output stall delays it. Reset (i_rst_n low at an edge) empties window, loads defaults.
module tvb_minmod_slope_limiter_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // sat_mean, sat_slope, prod_mean, prod_slope from bit 0 up
    input  logic [4*tvbm_pkg::WORD_BITS-1:0]     i_s_axis_tdata,
    // first_cell
    input  logic                                 i_s_axis_tuser,
    input  logic                                 i_s_axis_tlast,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // sat_left_node, sat_right_node, prod_left_node, prod_right_node from bit 0 up
    output logic [4*tvbm_pkg::WORD_BITS-1:0]     o_m_axis_tdata,
    // div_fault
    output logic                                 o_m_axis_tuser,
    output logic                                 o_m_axis_tlast,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tvbm_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [tvbm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import tvbm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIV,
        ST_LOAD,
        ST_COMMIT
    } t_state;

    // Window fill: empty, held cell starts a row, held cell has a left neighbor.
    localparam logic [1:0] FILL_EMPTY  = 2'd0;
    localparam logic [1:0] FILL_FIRST  = 2'd1;
    localparam logic [1:0] FILL_MID    = 2'd2;
    localparam logic [1:0] FILL_UNUSED = 2'd3;

    // Configuration registers.
    logic [SCALE_BITS-1:0] r_scale;
    logic [THR_BITS-1:0]   r_thr;
    logic [CW_BITS-1:0]    r_cw;
    logic [INV_BITS-1:0]   r_inv;
    logic                  r_mode;

    // Current input cell, held cell and the held cell's left neighbor.
    t_word r_xs, r_xss, r_xp, r_xps;
    t_word r_hsm, r_hss, r_hpm, r_hps;
    t_word r_osm, r_opm;
    logic [1:0] r_fill;

    // Scratch registers of the microprogram.
    t_word r_t0, r_t1, r_t2, r_t3, r_t4, r_t5, r_t6, r_t7, r_t8, r_t9;

    t_state              r_state;
    logic [PC_BITS-1:0]  r_pc;
    logic                r_a_pend;
    logic                r_final;
    logic                r_on_b;
    logic                r_fault;

    logic                          r_out_valid;
    logic [4*WORD_BITS-1:0]        r_out_data;
    logic                          r_out_user;
    logic                          r_out_last;

    t_uop     uop;
    t_word    opa, opb, opc;
    t_word    alu_y;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic  n_wr_en;
    t_dst  n_wr_dst;
    t_word n_wr_val;

    logic in_take;
    logic out_free;
    logic has_a;

    function automatic t_word pick(input t_src s);
        t_word v;
        case (s)
            S_XS:    v = r_xs;
            S_XSS:   v = r_xss;
            S_XP:    v = r_xp;
            S_XPS:   v = r_xps;
            S_HSM:   v = r_hsm;
            S_HSS:   v = r_hss;
            S_HPM:   v = r_hpm;
            S_HPS:   v = r_hps;
            S_OSM:   v = r_osm;
            S_OPM:   v = r_opm;
            S_CW:    v = {{(WORD_BITS-CW_BITS){1'b0}}, r_cw};
            S_INV:   v = {{(WORD_BITS-INV_BITS){1'b0}}, r_inv};
            S_SCALE: v = {{(WORD_BITS-SCALE_BITS){1'b0}}, r_scale};
            S_T0:    v = r_t0;
            S_T1:    v = r_t1;
            S_T2:    v = r_t2;
            S_T3:    v = r_t3;
            S_T4:    v = r_t4;
            S_T5:    v = r_t5;
            S_T6:    v = r_t6;
            S_T7:    v = r_t7;
            S_T8:    v = r_t8;
            S_T9:    v = r_t9;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign uop = uop_at(r_pc);

    always_comb begin
        opa = pick(uop.a);
        opb = pick(uop.b);
        opc = pick(uop.c);
    end

    // The single arithmetic unit for the microprogram's ALU steps; divisions use the divider.
    tvbm_alu u_alu (
        .i_op  (uop.op),
        .i_a   (opa),
        .i_b   (opb),
        .i_c   (opc),
        .i_thr ({{(WORD_BITS-THR_BITS){1'b0}}, r_thr}),
        .o_y   (alu_y)
    );

    assign div_req.start = (r_state == ST_RUN) && (uop.op == OP_DIV);
    assign div_req.num   = opa;
    assign div_req.den   = opb;

    tvbm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Scratch write port: ALU steps in ST_RUN, quotients when the divider finishes.
    always_comb begin
        n_wr_en  = 1'b0;
        n_wr_dst = uop.dst;
        n_wr_val = alu_y;
        if (r_state == ST_RUN && uop.op != OP_DIV && uop.op != OP_BRM &&
            uop.op != OP_JOUT) begin
            n_wr_en = 1'b1;
        end else if (r_state == ST_DIV && div_rsp.done) begin
            n_wr_en  = 1'b1;
            n_wr_val = div_rsp.quot;
        end
    end

    assign in_take  = i_s_axis_tvalid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || i_m_axis_tready;
    // A held cell gets its result when a cell of the same row follows it.
    assign has_a    = !i_s_axis_tuser && (r_fill != FILL_EMPTY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= SCALE_BITS'(65536);
            r_thr       <= '0;
            r_cw        <= CW_BITS'(655);
            r_inv       <= INV_BITS'(6553600);
            r_mode      <= 1'b0;
            r_fill      <= FILL_EMPTY;
            r_state     <= ST_IDLE;
            r_pc        <= PC_LIMIT;
            r_out_valid <= 1'b0;
            r_a_pend    <= 1'b0;
            r_final     <= 1'b0;
            r_on_b      <= 1'b0;
            r_fault     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_reg'(i_cfg_index))
                    REG_SLOPE_SCALE:    r_scale <= i_cfg_data[SCALE_BITS-1:0];
                    REG_TVB_THRESHOLD:  r_thr   <= i_cfg_data[THR_BITS-1:0];
                    REG_CELL_WIDTH:     r_cw    <= i_cfg_data[CW_BITS-1:0];
                    REG_INV_CELL_WIDTH: r_inv   <= i_cfg_data[INV_BITS-1:0];
                    REG_LIMIT_MODE:     r_mode  <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // The output register empties on a taken transaction unless it reloads now.
            if (i_m_axis_tready && !(r_state == ST_LOAD && out_free)) begin
                r_out_valid <= 1'b0;
            end

            if (n_wr_en) begin
                case (n_wr_dst)
                    D_T0:    r_t0 <= n_wr_val;
                    D_T1:    r_t1 <= n_wr_val;
                    D_T2:    r_t2 <= n_wr_val;
                    D_T3:    r_t3 <= n_wr_val;
                    D_T4:    r_t4 <= n_wr_val;
                    D_T5:    r_t5 <= n_wr_val;
                    D_T6:    r_t6 <= n_wr_val;
                    D_T7:    r_t7 <= n_wr_val;
                    D_T8:    r_t8 <= n_wr_val;
                    D_T9:    r_t9 <= n_wr_val;
                    default: ;
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_take) begin
                        r_xs     <= i_s_axis_tdata[WORD_BITS-1:0];
                        r_xss    <= i_s_axis_tdata[2*WORD_BITS-1:WORD_BITS];
                        r_xp     <= i_s_axis_tdata[3*WORD_BITS-1:2*WORD_BITS];
                        r_xps    <= i_s_axis_tdata[4*WORD_BITS-1:3*WORD_BITS];
                        r_a_pend <= has_a;
                        r_final  <= i_s_axis_tlast;
                        r_on_b   <= !has_a;
                        r_fault  <= 1'b0;
                        if (has_a) begin
                            r_pc <= (r_fill == FILL_MID) ? PC_LIMIT : PC_PASS_HELD;
                        end else begin
                            r_pc <= PC_PASS_IN;
                        end
                        // A row start that is not also a row end yields nothing yet.
                        r_state <= (has_a || i_s_axis_tlast) ? ST_RUN : ST_COMMIT;
                    end
                end
                ST_RUN: begin
                    case (uop.op)
                        OP_DIV:  r_state <= ST_DIV;
                        OP_BRM:  r_pc <= r_mode ? PC_MODE1 : r_pc + 1'b1;
                        OP_JOUT: r_pc <= PC_OUT;
                        default: begin
                            if (uop.last) begin
                                r_state <= ST_LOAD;
                            end else begin
                                r_pc <= r_pc + 1'b1;
                            end
                        end
                    endcase
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        r_fault <= r_fault | div_rsp.fault;
                        r_pc    <= r_pc + 1'b1;
                        r_state <= ST_RUN;
                    end
                end
                ST_LOAD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {r_t7, r_t6, r_t5, r_t4};
                        r_out_last  <= r_on_b;
                        r_out_user  <= !r_on_b && r_fault;
                        if (!r_on_b && r_final) begin
                            // The new cell also ends the row: it passes through next.
                            r_on_b  <= 1'b1;
                            r_pc    <= PC_PASS_IN;
                            r_state <= ST_RUN;
                        end else begin
                            r_state <= ST_COMMIT;
                        end
                    end
                end
                ST_COMMIT: begin
                    if (r_a_pend) begin
                        r_osm <= r_hsm;
                        r_opm <= r_hpm;
                    end
                    r_hsm <= r_xs;
                    r_hss <= r_xss;
                    r_hpm <= r_xp;
                    r_hps <= r_xps;
                    if (r_final) begin
                        r_fill <= FILL_EMPTY;
                    end else begin
                        r_fill <= r_a_pend ? FILL_MID : FILL_FIRST;
                    end
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;
    assign o_cfg_ready     = 1'b1;

    // The block works on one cell at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while a cell is in work");

    // A row-end pass-through never carries a division fault.
    a_fault_not_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> !o_m_axis_tlast)
        else $error("division fault on a pass-through result");

    // Divisions belong to concentration limiting only.
    a_div_mode1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> r_mode)
        else $error("divider used in product limiting mode");

    a_fill_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != FILL_UNUSED)
        else $error("window fill out of range");

endmodule
